// ----- rtl/trlz_pkg.sv -----
`timescale 1ns / 1ps

package trlz_pkg;

    // Command codes carried on s_tuser
    typedef enum logic [2:0] {
        CMD_CLEAR  = 3'd0,
        CMD_LINE   = 3'd1,
        CMD_FILL   = 3'd2,
        CMD_WIRE   = 3'd3,
        CMD_READ   = 3'd4
    } cmd_t;

    // Main sequencer states
    typedef enum logic [3:0] {
        ST_WIPE,
        ST_IDLE,
        ST_READ_ADDR,
        ST_READ_DATA,
        ST_LINE_SETUP,
        ST_LINE_CHECK,
        ST_LN_GO,
        ST_LN_WAIT,
        ST_PLOT_RD,
        ST_PLOT_WR,
        ST_TRI_SORT,
        ST_TRI_ROW,
        ST_TRI_GO,
        ST_TRI_WAIT
    } st_t;

    // Interpolation unit states
    typedef enum logic [1:0] {
        L_IDLE,
        L_DIV,
        L_DONE
    } lst_t;

    // Fixed edge colors of the wire triangle
    localparam logic [31:0] WIRE_RED   = 32'hFF0000FF;
    localparam logic [31:0] WIRE_GREEN = 32'h00FF00FF;
    localparam logic [31:0] WIRE_BLUE  = 32'h0000FFFF;

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Y = 2'd1;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef struct packed {
        logic signed [11:0] x;
        logic signed [11:0] y;
        logic signed [11:0] z;
    } vtx_t;

    // Request to the interpolation unit: a + p*(b-a)/n
    typedef struct packed {
        logic               start;
        logic signed [11:0] a;
        logic signed [11:0] b;
        logic [11:0]        p;
        logic [11:0]        n;
    } lerp_req_t;

    // Write request to the frame stores
    typedef struct packed {
        logic        we;
        logic [31:0] color;
        logic [7:0]  depth;
    } wr_t;

    function automatic logic signed [11:0] clamp_z(input logic signed [8:0] z);
        logic signed [11:0] r;
        if (z > 9'sd0)
            r = 12'sd0;
        else if (z < -9'sd255)
            r = -12'sd255;
        else
            r = 12'(z);
        return r;
    endfunction

    function automatic logic [11:0] absdiff(input logic signed [11:0] a,
                                            input logic signed [11:0] b);
        logic signed [12:0] d;
        logic [12:0]        m;
        d = 13'(a) - 13'(b);
        m = d[12] ? 13'(-d) : 13'(d);
        return m[11:0];
    endfunction

    function automatic logic signed [11:0] pick(input vtx_t v, input logic [1:0] c);
        logic signed [11:0] r;
        case (c)
            COMP_X:  r = v.x;
            COMP_Y:  r = v.y;
            default: r = v.z;
        endcase
        return r;
    endfunction

    // floor(ch * d / 255) for 8-bit operands
    function automatic logic [7:0] scale8(input logic [7:0] ch, input logic [7:0] d);
        logic [16:0] v;
        logic [16:0] q;
        v = 17'(ch) * 17'(d);
        q = (v + (v >> 8) + 17'd1) >> 8;
        return q[7:0];
    endfunction

    function automatic logic [31:0] scale_color(input logic [31:0] c, input logic [7:0] d);
        return {scale8(c[31:24], d), scale8(c[23:16], d), scale8(c[15:8], d), c[7:0]};
    endfunction

endpackage

// ----- rtl/triangle_line_raster_zbuffer.sv -----
`timescale 1ns / 1ps

// Channel  Dir  Payload
// s_*      in   tuser: command; tdata: three vertices (x, y, z) and color_rgba
// m_*      out  tdata: pixel_color, pixel_depth, inside_frame (read command only)
//
// After reset a clearing pass writes every store entry with s_tready low. A clear
// command takes the same sweep. A read passes through the address and data states
// before its result is registered. Each drawn point costs three interpolations on
// the shared serial divider plus a depth read-modify-write; a filled triangle adds
// six interpolations per row.
// s_tready is high only in idle while the output register is free or draining.

module triangle_line_raster_zbuffer #(
    parameter int FRAME_WIDTH  = 128,
    parameter int FRAME_HEIGHT = 128
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [2:0]   s_tuser,   // command
    input  logic [135:0] s_tdata,   // x_first, y_first, z_first, x_second, y_second,
                                    // z_second, x_third, y_third, z_third, color_rgba
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [47:0]  m_tdata    // pixel_color, pixel_depth, inside_frame
);
    import trlz_pkg::*;

    localparam int STORE_SIZE = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int IDX_W      = $clog2(STORE_SIZE);

    st_t                state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    vtx_t               v0_reg, v0_next, v1_reg, v1_next, v2_reg, v2_next;
    vtx_t               s_reg, s_next, e_reg, e_next;
    logic [31:0]        color_reg, color_next;
    logic [31:0]        wipe_color_reg, wipe_color_next;
    logic [IDX_W-1:0]   wipe_cnt_reg, wipe_cnt_next;
    logic [11:0]        n_reg, n_next, p_reg, p_next;
    logic [11:0]        i_reg, i_next;
    logic [11:0]        e0_reg, e0_next, e1_reg, e1_next, e2_reg, e2_next;
    logic [1:0]         comp_reg, comp_next;
    logic               half_reg, half_next;
    logic [1:0]         seg_reg, seg_next;
    logic signed [11:0] px_reg, px_next, py_reg, py_next, pz_reg, pz_next;
    logic               out_valid_reg, out_valid_next;
    logic [31:0]        out_color_reg, out_color_next;
    logic [7:0]         out_depth_reg, out_depth_next;
    logic               out_inside_reg, out_inside_next;

    lerp_req_t          lreq;
    logic               lerp_done;
    logic signed [11:0] lerp_res;
    wr_t                wr;
    logic [IDX_W-1:0]   waddr;
    logic [IDX_W-1:0]   pix_idx;
    logic               in_frame;
    logic [31:0]        rd_color;
    logic [7:0]         rd_depth;
    logic [11:0]        negz;
    logic [7:0]         depth_new;
    vtx_t               in_v0, in_v1, in_v2;
    vtx_t               t0, t1, t2, tt;
    logic [11:0]        lw, lh;

    trlz_lerp u_lerp (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (lreq),
        .done   (lerp_done),
        .result (lerp_res)
    );

    trlz_store #(
        .DEPTH (STORE_SIZE),
        .IDX_W (IDX_W)
    ) u_store (
        .clk      (clk),
        .wr       (wr),
        .waddr    (waddr),
        .raddr    (pix_idx),
        .rd_color (rd_color),
        .rd_depth (rd_depth)
    );

    // input unpacking with depth clamp
    assign in_v0 = '{x: s_tdata[11:0],  y: s_tdata[23:12], z: clamp_z(s_tdata[32:24])};
    assign in_v1 = '{x: s_tdata[44:33], y: s_tdata[56:45], z: clamp_z(s_tdata[65:57])};
    assign in_v2 = '{x: s_tdata[77:66], y: s_tdata[89:78], z: clamp_z(s_tdata[98:90])};

    // current pixel position, bounds and store index
    assign in_frame = !px_reg[11] && !py_reg[11]
                      && ({1'b0, px_reg[10:0]} < 12'(FRAME_WIDTH))
                      && ({1'b0, py_reg[10:0]} < 12'(FRAME_HEIGHT));
    assign pix_idx = IDX_W'(px_reg[10:0])
                     + IDX_W'(IDX_W'(py_reg[10:0]) * IDX_W'(FRAME_WIDTH));
    assign negz      = 12'(-pz_reg);
    assign depth_new = negz[7:0];

    // store write port
    always_comb
    begin
        wr.we    = 1'b0;
        wr.color = wipe_color_reg;
        wr.depth = 8'd0;
        waddr    = wipe_cnt_reg;
        if (state_reg == ST_WIPE)
        begin
            wr.we = 1'b1;
        end
        else if (state_reg == ST_PLOT_WR && rd_depth < depth_new)
        begin
            wr.we    = 1'b1;
            wr.color = scale_color(color_reg, depth_new);
            wr.depth = depth_new;
            waddr    = pix_idx;
        end
    end

    // interpolation operand select
    always_comb
    begin
        lreq.start = (state_reg == ST_LN_GO) || (state_reg == ST_TRI_GO);
        if (state_reg == ST_LN_GO)
        begin
            lreq.a = pick(s_reg, comp_reg);
            lreq.b = pick(e_reg, comp_reg);
            lreq.p = p_reg;
            lreq.n = n_reg;
        end
        else if (!half_reg)
        begin
            lreq.a = pick(v0_reg, comp_reg);
            lreq.b = pick(v2_reg, comp_reg);
            lreq.p = i_reg;
            lreq.n = e0_reg;
        end
        else if (i_reg < e1_reg)
        begin
            lreq.a = pick(v0_reg, comp_reg);
            lreq.b = pick(v1_reg, comp_reg);
            lreq.p = i_reg;
            lreq.n = e1_reg;
        end
        else
        begin
            lreq.a = pick(v1_reg, comp_reg);
            lreq.b = pick(v2_reg, comp_reg);
            lreq.p = i_reg - e1_reg;
            lreq.n = e2_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_WIPE;
            wipe_cnt_reg   <= '0;
            wipe_color_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            wipe_cnt_reg   <= wipe_cnt_next;
            wipe_color_reg <= wipe_color_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        v0_reg         <= v0_next;
        v1_reg         <= v1_next;
        v2_reg         <= v2_next;
        s_reg          <= s_next;
        e_reg          <= e_next;
        color_reg      <= color_next;
        n_reg          <= n_next;
        p_reg          <= p_next;
        i_reg          <= i_next;
        e0_reg         <= e0_next;
        e1_reg         <= e1_next;
        e2_reg         <= e2_next;
        comp_reg       <= comp_next;
        half_reg       <= half_next;
        seg_reg        <= seg_next;
        px_reg         <= px_next;
        py_reg         <= py_next;
        pz_reg         <= pz_next;
        out_color_reg  <= out_color_next;
        out_depth_reg  <= out_depth_next;
        out_inside_reg <= out_inside_next;
    end

    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        v0_next         = v0_reg;
        v1_next         = v1_reg;
        v2_next         = v2_reg;
        s_next          = s_reg;
        e_next          = e_reg;
        color_next      = color_reg;
        wipe_color_next = wipe_color_reg;
        wipe_cnt_next   = wipe_cnt_reg;
        n_next          = n_reg;
        p_next          = p_reg;
        i_next          = i_reg;
        e0_next         = e0_reg;
        e1_next         = e1_reg;
        e2_next         = e2_reg;
        comp_next       = comp_reg;
        half_next       = half_reg;
        seg_next        = seg_reg;
        px_next         = px_reg;
        py_next         = py_reg;
        pz_next         = pz_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_color_next  = out_color_reg;
        out_depth_next  = out_depth_reg;
        out_inside_next = out_inside_reg;
        t0 = v0_reg;
        t1 = v1_reg;
        t2 = v2_reg;
        tt = v0_reg;
        lw = absdiff(e_reg.x, s_reg.x);
        lh = absdiff(e_reg.y, s_reg.y);

        unique case (state_reg)
            ST_WIPE:
            begin
                wipe_cnt_next = wipe_cnt_reg + 1'b1;
                if (wipe_cnt_reg == IDX_W'(STORE_SIZE - 1))
                begin
                    wipe_cnt_next = '0;
                    state_next    = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    cmd_next   = cmd_t'(s_tuser);
                    v0_next    = in_v0;
                    v1_next    = in_v1;
                    v2_next    = in_v2;
                    s_next     = in_v0;
                    e_next     = in_v1;
                    color_next = s_tdata[130:99];
                    px_next    = in_v0.x;
                    py_next    = in_v0.y;
                    seg_next   = 2'd0;
                    i_next     = '0;
                    case (cmd_t'(s_tuser))
                        CMD_CLEAR:
                        begin
                            wipe_color_next = s_tdata[130:99];
                            state_next      = ST_WIPE;
                        end
                        CMD_LINE:  state_next = ST_LINE_SETUP;
                        CMD_FILL:  state_next = ST_TRI_SORT;
                        CMD_WIRE:
                        begin
                            color_next = WIRE_RED;
                            state_next = ST_LINE_SETUP;
                        end
                        CMD_READ:  state_next = ST_READ_ADDR;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_READ_ADDR:
            begin
                state_next = ST_READ_DATA;
            end
            ST_READ_DATA:
            begin
                out_valid_next  = 1'b1;
                out_inside_next = in_frame;
                out_color_next  = in_frame ? rd_color : 32'd0;
                out_depth_next  = in_frame ? rd_depth : 8'd0;
                state_next      = ST_IDLE;
            end
            ST_LINE_SETUP:
            begin
                n_next     = (lw <= lh) ? lh : lw;
                p_next     = '0;
                state_next = ST_LINE_CHECK;
            end
            ST_LINE_CHECK:
            begin
                if (p_reg < n_reg)
                begin
                    comp_next  = COMP_X;
                    state_next = ST_LN_GO;
                end
                else if (cmd_reg == CMD_FILL)
                begin
                    i_next     = i_reg + 12'd1;
                    state_next = ST_TRI_ROW;
                end
                else if (cmd_reg == CMD_WIRE && seg_reg == 2'd0)
                begin
                    seg_next   = 2'd1;
                    s_next     = v1_reg;
                    e_next     = v2_reg;
                    color_next = WIRE_GREEN;
                    state_next = ST_LINE_SETUP;
                end
                else if (cmd_reg == CMD_WIRE && seg_reg == 2'd1)
                begin
                    seg_next   = 2'd2;
                    s_next     = v2_reg;
                    e_next     = v0_reg;
                    color_next = WIRE_BLUE;
                    state_next = ST_LINE_SETUP;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LN_GO:
            begin
                state_next = ST_LN_WAIT;
            end
            ST_LN_WAIT:
            begin
                if (lerp_done)
                begin
                    case (comp_reg)
                        COMP_X:  px_next = lerp_res;
                        COMP_Y:  py_next = lerp_res;
                        default: pz_next = lerp_res;
                    endcase
                    if (comp_reg == COMP_Z)
                    begin
                        state_next = ST_PLOT_RD;
                    end
                    else
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_LN_GO;
                    end
                end
            end
            ST_PLOT_RD:
            begin
                // points off the frame skip the store
                if (in_frame)
                begin
                    state_next = ST_PLOT_WR;
                end
                else
                begin
                    p_next     = p_reg + 12'd1;
                    state_next = ST_LINE_CHECK;
                end
            end
            ST_PLOT_WR:
            begin
                p_next     = p_reg + 12'd1;
                state_next = ST_LINE_CHECK;
            end
            ST_TRI_SORT:
            begin
                if (t0.y > t1.y)
                begin
                    tt = t0; t0 = t1; t1 = tt;
                end
                if (t0.y > t2.y)
                begin
                    tt = t0; t0 = t2; t2 = tt;
                end
                if (t1.y > t2.y)
                begin
                    tt = t1; t1 = t2; t2 = tt;
                end
                v0_next    = t0;
                v1_next    = t1;
                v2_next    = t2;
                e0_next    = absdiff(t0.y, t2.y);
                e1_next    = absdiff(t0.y, t1.y);
                e2_next    = absdiff(t1.y, t2.y);
                state_next = ST_TRI_ROW;
            end
            ST_TRI_ROW:
            begin
                if (i_reg < e0_reg)
                begin
                    comp_next  = COMP_X;
                    half_next  = 1'b0;
                    state_next = ST_TRI_GO;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_TRI_GO:
            begin
                state_next = ST_TRI_WAIT;
            end
            ST_TRI_WAIT:
            begin
                if (lerp_done)
                begin
                    if (!half_reg)
                    begin
                        case (comp_reg)
                            COMP_X:  s_next.x = lerp_res;
                            COMP_Y:  s_next.y = lerp_res;
                            default: s_next.z = lerp_res;
                        endcase
                    end
                    else
                    begin
                        case (comp_reg)
                            COMP_X:  e_next.x = lerp_res;
                            COMP_Y:  e_next.y = lerp_res;
                            default: e_next.z = lerp_res;
                        endcase
                    end
                    if (comp_reg != COMP_Z)
                    begin
                        comp_next  = comp_reg + 2'd1;
                        state_next = ST_TRI_GO;
                    end
                    else if (!half_reg)
                    begin
                        comp_next  = COMP_X;
                        half_next  = 1'b1;
                        state_next = ST_TRI_GO;
                    end
                    else
                    begin
                        state_next = ST_LINE_SETUP;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_inside_reg, out_depth_reg, out_color_reg};

    // interpolation results only arrive while the sequencer waits for them
    a_lerp_wait: assert property (@(posedge clk) disable iff (!rst_n)
        lerp_done |-> (state_reg == ST_LN_WAIT || state_reg == ST_TRI_WAIT))
        else $error("interpolation result outside a wait state");

    // no store write while a new command can be taken
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        wr.we |-> !s_tready)
        else $error("store write while idle");

    // a result appears only after a read completes
    a_out_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_READ_DATA))
        else $error("result without a read");

endmodule

// ----- rtl/trlz_lerp.sv -----
`timescale 1ns / 1ps

module trlz_lerp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  trlz_pkg::lerp_req_t         req,
    output logic                        done,
    output logic signed [11:0]          result
);
    import trlz_pkg::*;

    lst_t               lst_reg, lst_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic [11:0]        rem_reg, rem_next;
    logic [23:0]        quo_reg, quo_next;
    logic [11:0]        den_reg, den_next;
    logic               neg_reg, neg_next;
    logic signed [11:0] base_reg, base_next;

    logic signed [12:0] diff;
    logic [11:0]        mag;
    logic [12:0]        trial;
    logic signed [12:0] qs;
    logic signed [12:0] sum;

    // state and datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lst_reg <= L_IDLE;
            cnt_reg <= '0;
        end
        else
        begin
            lst_reg <= lst_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        den_reg  <= den_next;
        neg_reg  <= neg_next;
        base_reg <= base_next;
    end

    // restoring division of |p*(b-a)| by n, one quotient bit per cycle
    always_comb
    begin
        lst_next  = lst_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        base_next = base_reg;
        diff      = 13'(req.b) - 13'(req.a);
        mag       = diff[12] ? 12'(-diff) : 12'(diff);
        trial     = {rem_reg, quo_reg[23]};
        unique case (lst_reg)
            L_IDLE:
            begin
                if (req.start)
                begin
                    base_next = req.a;
                    neg_next  = diff[12];
                    den_next  = req.n;
                    rem_next  = '0;
                    cnt_next  = '0;
                    if (req.n == 12'd0 || req.a == req.b)
                    begin
                        quo_next = '0;
                        lst_next = L_DONE;
                    end
                    else
                    begin
                        quo_next = 24'(req.p) * 24'(mag);
                        lst_next = L_DIV;
                    end
                end
            end
            L_DIV:
            begin
                if (trial >= {1'b0, den_reg})
                begin
                    rem_next = 12'(trial - {1'b0, den_reg});
                    quo_next = {quo_reg[22:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[11:0];
                    quo_next = {quo_reg[22:0], 1'b0};
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd23)
                    lst_next = L_DONE;
            end
            L_DONE:
            begin
                lst_next = L_IDLE;
            end
            default:
            begin
                lst_next = L_IDLE;
            end
        endcase
    end

    // quotient magnitude never exceeds |b-a|, so the low 12 bits hold it
    assign qs     = neg_reg ? -$signed({1'b0, quo_reg[11:0]}) : $signed({1'b0, quo_reg[11:0]});
    assign sum    = 13'(base_reg) + qs;
    assign result = sum[11:0];
    assign done   = (lst_reg == L_DONE);

endmodule

// ----- rtl/trlz_store.sv -----
`timescale 1ns / 1ps

module trlz_store #(
    parameter int DEPTH = 16384,
    parameter int IDX_W = 14
) (
    input  logic              clk,
    input  trlz_pkg::wr_t     wr,
    input  logic [IDX_W-1:0]  waddr,
    input  logic [IDX_W-1:0]  raddr,
    output logic [31:0]       rd_color,
    output logic [7:0]        rd_depth
);
    import trlz_pkg::*;

    logic [31:0] color_mem [DEPTH];
    logic [7:0]  depth_mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            color_mem[waddr] <= wr.color;
            depth_mem[waddr] <= wr.depth;
        end
        rd_color <= color_mem[raddr];
        rd_depth <= depth_mem[raddr];
    end

endmodule
